// ===== hw/rtl/flpti_pkg.sv =====
// Package for the four-level page table insert block.
// Holds field widths, sequencer step and micro-op codes and the microcode ROM.
// No dependencies.
`default_nettype none

package flpti_pkg;

  // Field widths
  localparam int VA_W      = 48;
  localparam int PA_W      = 64;
  localparam int FLAGS_W   = 12;
  localparam int FRAME_W   = 40;
  localparam int ENTRY_W   = 64;
  localparam int LEAF_W    = 52;
  localparam int IDX_W     = 9;
  localparam int ALLOC_W   = 2;

  // Default store size in table pages
  localparam int TABLE_PAGES_DEF = 16;

  // Last intermediate level (levels 0..2 are walked, level 3 is the leaf)
  localparam logic [1:0] LAST_LVL = 2'd2;

  // Link entry flags: present, writable, user
  localparam logic [11:0] LINK_FLAGS = 12'h007;

  // Sequencer step addresses
  typedef enum logic [2:0] {
    STEP_CLEAR  = 3'd0,
    STEP_ACCEPT = 3'd1,
    STEP_READ   = 3'd2,
    STEP_EVAL   = 3'd3,
    STEP_FINISH = 3'd4
  } step_t;

  // Micro-ops driving the datapath
  typedef enum logic [2:0] {
    UOP_CLEAR,   // write zero to the clear address, hold until sweep done
    UOP_ACCEPT,  // take an input item, hold until one arrives
    UOP_READ,    // read the entry of the current level
    UOP_EVAL,    // follow or allocate the link, branch out on stop or last level
    UOP_FINISH   // write the leaf unless the walk failed, load the result, hold while output is full
  } uop_t;

  // One control word: operation, fall-through step, branch target
  typedef struct packed {
    uop_t  op;
    step_t nxt;
    step_t jmp;
  } ucode_t;

  // Microcode ROM
  function automatic ucode_t ucode_rom(input step_t pc);
    ucode_t w;
    unique case (pc)
      STEP_CLEAR:  w = '{op: UOP_CLEAR,  nxt: STEP_ACCEPT, jmp: STEP_CLEAR};
      STEP_ACCEPT: w = '{op: UOP_ACCEPT, nxt: STEP_READ,   jmp: STEP_ACCEPT};
      STEP_READ:   w = '{op: UOP_READ,   nxt: STEP_EVAL,   jmp: STEP_EVAL};
      STEP_EVAL:   w = '{op: UOP_EVAL,   nxt: STEP_READ,   jmp: STEP_FINISH};
      STEP_FINISH: w = '{op: UOP_FINISH, nxt: STEP_ACCEPT, jmp: STEP_FINISH};
      default:     w = '{op: UOP_CLEAR,  nxt: STEP_CLEAR,  jmp: STEP_CLEAR};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/four_level_page_table_insert.sv =====
// Walk: accept, then the level steps, then finish; a walk that stops early goes straight to finish.
// Items are taken one at a time; each of the three intermediate levels takes a read and an
// evaluate step on the table store.
// Reset: synchronous active-low; after reset a clearing pass writes all TABLE_PAGES*512
// store entries with in_ready low; config writes are taken throughout.
// Depends on flpti_pkg. Top level: microcoded walker over a one-read one-write table store.
`default_nettype none

module four_level_page_table_insert
  import flpti_pkg::*;
#(
  parameter int TABLE_PAGES = TABLE_PAGES_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // configuration write
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [FRAME_W-1:0]  cfg_table_base_frame,
  // input items
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [VA_W-1:0]     in_virt_addr,
  input  wire logic [PA_W-1:0]     in_phys_addr,
  input  wire logic [FLAGS_W-1:0]  in_page_flags,
  // result items
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     out_out_of_pages,
  output logic [ALLOC_W-1:0]       out_tables_allocated,
  output logic [LEAF_W-1:0]        out_leaf_entry_addr
);

  localparam int PAGE_W = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
  localparam int NFP_W  = $clog2(TABLE_PAGES + 1);
  localparam int ADDR_W = PAGE_W + IDX_W;
  localparam int DEPTH  = TABLE_PAGES * (1 << IDX_W);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
  localparam logic [NFP_W-1:0]  PAGES_N   = NFP_W'(TABLE_PAGES);
  localparam logic [LEAF_W-1:0] PAGES_REL = LEAF_W'(TABLE_PAGES);

  // Sequencer and control state
  step_t               pc_r, pc_nxt;
  logic [ADDR_W-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic [NFP_W-1:0]    nfp_r, nfp_nxt;
  logic [FRAME_W-1:0]  base_r;
  logic                out_valid_r, out_valid_nxt;

  // Walk state
  logic [VA_W-1:0]     va_r, va_nxt;
  logic [PA_W-1:0]     pa_r, pa_nxt;
  logic [FLAGS_W-1:0]  flags_r, flags_nxt;
  logic [PAGE_W-1:0]   page_r, page_nxt;
  logic [1:0]          lvl_r, lvl_nxt;
  logic [ALLOC_W-1:0]  alloc_r, alloc_nxt;
  logic                fail_r, fail_nxt;

  // Result registers
  logic                oop_r, oop_nxt;
  logic [ALLOC_W-1:0]  talloc_r, talloc_nxt;
  logic [LEAF_W-1:0]   leaf_r, leaf_nxt;

  // Store: 64-bit entry plus a tag set when written after its page was allocated
  logic [ENTRY_W:0]    mem [DEPTH];
  logic [ENTRY_W:0]    rd_data_r;
  logic [ADDR_W-1:0]   rd_addr;
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic [ENTRY_W:0]    wr_data;

  ucode_t              uw;
  logic [IDX_W-1:0]    idx_sel;
  logic [ENTRY_W-1:0]  entry;
  logic [LEAF_W:0]     rel;
  logic                link_ok;
  logic [FRAME_W:0]    new_frame;
  logic [FRAME_W-1:0]  leaf_frame;
  logic                out_free;

  assign uw        = ucode_rom(pc_r);
  assign cfg_ready = 1'b1;
  assign in_ready  = (uw.op == UOP_ACCEPT);
  assign out_free  = !out_valid_r || out_ready;

  // Index of the level being walked
  always_comb begin
    unique case (lvl_r)
      2'd0:    idx_sel = va_r[47:39];
      2'd1:    idx_sel = va_r[38:30];
      2'd2:    idx_sel = va_r[29:21];
      default: idx_sel = va_r[20:12];
    endcase
  end

  assign rd_addr = {page_r, idx_sel};

  // Entry seen by the walk: an untagged entry of an allocated page was zeroed at allocation
  assign entry = (!rd_data_r[ENTRY_W] && (NFP_W'(page_r) < nfp_r)) ?
                 '0 : rd_data_r[ENTRY_W-1:0];

  // Link target relative to the store base
  assign rel     = {1'b0, entry[63:12]} - (LEAF_W + 1)'(base_r);
  assign link_ok = !rel[LEAF_W] && (rel[LEAF_W-1:0] < PAGES_REL);

  // Frame adders for a new link and for the leaf address
  assign new_frame  = (FRAME_W + 1)'(base_r) + (FRAME_W + 1)'(nfp_r);
  assign leaf_frame = base_r + FRAME_W'(page_r);

  // Sequencer next step and datapath controls
  always_comb begin
    pc_nxt        = pc_r;
    clr_cnt_nxt   = clr_cnt_r;
    nfp_nxt       = nfp_r;
    out_valid_nxt = out_valid_r;
    va_nxt        = va_r;
    pa_nxt        = pa_r;
    flags_nxt     = flags_r;
    page_nxt      = page_r;
    lvl_nxt       = lvl_r;
    alloc_nxt     = alloc_r;
    fail_nxt      = fail_r;
    oop_nxt       = oop_r;
    talloc_nxt    = talloc_r;
    leaf_nxt      = leaf_r;
    wr_en         = 1'b0;
    wr_addr       = rd_addr;
    wr_data       = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (uw.op)
      UOP_CLEAR: begin
        wr_en       = 1'b1;
        wr_addr     = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        pc_nxt      = (clr_cnt_r == LAST_ADDR) ? uw.nxt : uw.jmp;
      end
      UOP_ACCEPT: begin
        if (in_valid) begin
          va_nxt    = in_virt_addr;
          pa_nxt    = in_phys_addr;
          flags_nxt = in_page_flags;
          page_nxt  = '0;
          lvl_nxt   = '0;
          alloc_nxt = '0;
          fail_nxt  = 1'b0;
          pc_nxt    = uw.nxt;
        end else begin
          pc_nxt = uw.jmp;
        end
      end
      UOP_READ: begin
        pc_nxt = uw.nxt;
      end
      UOP_EVAL: begin
        lvl_nxt = lvl_r + 1'b1;
        if (entry[0]) begin
          // present: follow the link if it lands in the store
          if (link_ok) begin
            page_nxt = rel[PAGE_W-1:0];
          end else begin
            fail_nxt = 1'b1;
          end
        end else if (nfp_r >= PAGES_N) begin
          fail_nxt = 1'b1;
        end else begin
          // missing: link the next free page
          nfp_nxt   = nfp_r + 1'b1;
          page_nxt  = nfp_r[PAGE_W-1:0];
          alloc_nxt = alloc_r + 1'b1;
          wr_en     = 1'b1;
          wr_data   = {(NFP_W'(page_r) <= nfp_r), 11'd0, new_frame, LINK_FLAGS};
        end
        pc_nxt = (fail_nxt || (lvl_r == LAST_LVL)) ? uw.jmp : uw.nxt;
      end
      UOP_FINISH: begin
        if (out_free) begin
          wr_en         = !fail_r;
          wr_addr       = {page_r, va_r[20:12]};
          wr_data       = {(NFP_W'(page_r) < nfp_r),
                           pa_r | {{(PA_W - FLAGS_W){1'b0}}, flags_r}};
          oop_nxt       = fail_r;
          talloc_nxt    = alloc_r;
          leaf_nxt      = fail_r ? '0 : {leaf_frame, va_r[20:12], 3'b000};
          out_valid_nxt = 1'b1;
          pc_nxt        = uw.nxt;
        end else begin
          pc_nxt = uw.jmp;
        end
      end
      default: begin
        pc_nxt = STEP_CLEAR;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= STEP_CLEAR;
      clr_cnt_r   <= '0;
      nfp_r       <= NFP_W'(1);
      out_valid_r <= 1'b0;
      base_r      <= '0;
    end else begin
      pc_r        <= pc_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      nfp_r       <= nfp_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        base_r <= cfg_table_base_frame;
      end
    end
  end

  // Walk and result payload
  always_ff @(posedge clk) begin
    va_r     <= va_nxt;
    pa_r     <= pa_nxt;
    flags_r  <= flags_nxt;
    page_r   <= page_nxt;
    lvl_r    <= lvl_nxt;
    alloc_r  <= alloc_nxt;
    fail_r   <= fail_nxt;
    oop_r    <= oop_nxt;
    talloc_r <= talloc_nxt;
    leaf_r   <= leaf_nxt;
  end

  // Table store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign out_valid            = out_valid_r;
  assign out_out_of_pages     = oop_r;
  assign out_tables_allocated = talloc_r;
  assign out_leaf_entry_addr  = leaf_r;

endmodule

`default_nettype wire

// ===== hw/rtl/flpti_checker.sv =====
// Port-level checker for the four-level page table insert block, with its bind.
// Depends on flpti_pkg and the top level's port names.
`default_nettype none

module flpti_checker
  import flpti_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic               out_out_of_pages,
  input wire logic [ALLOC_W-1:0] out_tables_allocated,
  input wire logic [LEAF_W-1:0]  out_leaf_entry_addr
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_out_of_pages)
      && $stable(out_tables_allocated) && $stable(out_leaf_entry_addr))
    else $error("result changed while stalled");

  // A failed walk reports no leaf address
  a_fail_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_pages |-> out_leaf_entry_addr == '0)
    else $error("leaf address on failed walk");

  // One item at a time: no accept in the cycle after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("back-to-back accept");

  // Store clearing follows reset, so no item is taken right after it
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input ready right after reset");

endmodule

bind four_level_page_table_insert flpti_checker u_flpti_checker (.*);

`default_nettype wire
